/* rtl/sml_pkg.sv */
// ----------------------------------------------------------------------------
// sml_pkg
// Shared types and constants of the small matrix determinant / inverse block.
// ----------------------------------------------------------------------------
package sml_pkg;

  // fraction bits of the fixed-point format
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned N_ELEM  = 9;
  localparam int unsigned ELEM_W  = 32;
  // adjugate entries: 2x2 minors of 32-bit elements, signed
  localparam int unsigned ADJ_W   = 65;
  // determinant at three times the fraction bits, signed
  localparam int unsigned DET_W   = 98;
  // quotient bits kept by the divider; anything wider saturates anyway
  localparam int unsigned QUO_W   = 34;
  localparam int unsigned REM_W   = DET_W + QUO_W;

  // multiplier schedule: two products per minor, then six for the determinant
  localparam int unsigned MINOR_STEPS = 18;
  localparam int unsigned MUL_LAST    = 24;

  // link queue
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  // element indices (row-major) of minor j = P*S - Q*R
  localparam logic [3:0] MINOR_P [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] MINOR_S [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] MINOR_Q [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] MINOR_R [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};
  // adjugate entries that pair with the first row in the expansion
  localparam logic [3:0] DET_ADJ [3] = '{4'd0, 4'd3, 4'd6};

  // entries of the result that each size fills
  localparam logic [N_ELEM-1:0] USED_1X1 = 9'b000000001;
  localparam logic [N_ELEM-1:0] USED_2X2 = 9'b000011011;
  localparam logic [N_ELEM-1:0] USED_3X3 = 9'b111111111;

  localparam logic [1:0] MODE_1X1 = 2'd0;
  localparam logic [1:0] MODE_2X2 = 2'd1;
  localparam logic [1:0] MODE_3X3 = 2'd2;
  localparam logic [1:0] MODE_3X3_ALT = 2'd3;

  typedef enum logic [1:0] {
    SIZE_1X1,
    SIZE_2X2,
    SIZE_3X3
  } size_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_DET,
    BS_DLOAD,
    BS_DSTEP,
    BS_DSTORE,
    BS_OUT
  } bstate_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] elem_r0c0;
    logic signed [31:0] elem_r0c1;
    logic signed [31:0] elem_r0c2;
    logic signed [31:0] elem_r1c0;
    logic signed [31:0] elem_r1c1;
    logic signed [31:0] elem_r1c2;
    logic signed [31:0] elem_r2c0;
    logic signed [31:0] elem_r2c1;
    logic signed [31:0] elem_r2c2;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] det_value;
    logic signed [31:0] inv_r0c0;
    logic signed [31:0] inv_r0c1;
    logic signed [31:0] inv_r0c2;
    logic signed [31:0] inv_r1c0;
    logic signed [31:0] inv_r1c1;
    logic signed [31:0] inv_r1c2;
    logic signed [31:0] inv_r2c0;
    logic signed [31:0] inv_r2c1;
    logic signed [31:0] inv_r2c2;
    logic               singular;
    logic               overflow;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    size_e                          size;
    logic [N_ELEM-1:0]              used;
    logic [N_ELEM-1:0][ELEM_W-1:0]  m;
  } cls_item_t;

  // queue handshake towards the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/sml_front.sv */
// ----------------------------------------------------------------------------
// sml_front
// Input stage: takes one beat, sorts out the matrix size and the used
// entries, and hands the classified item to the link queue.
// ----------------------------------------------------------------------------
module sml_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  sml_pkg::in_item_t  item_i,
  output logic               q_push_o,
  output sml_pkg::cls_item_t q_item_o,
  input  sml_pkg::q_stat_t   q_stat_i
);
  import sml_pkg::*;

  logic      valid_q, valid_d;
  cls_item_t item_q, item_d;
  logic      accept;

  assign q_push_o = valid_q && !q_stat_i.full;
  assign full     = valid_q && q_stat_i.full;
  assign accept   = push && !full;
  assign q_item_o = item_q;

  // classify the incoming beat
  always_comb begin
    item_d.m = {item_i.elem_r2c2, item_i.elem_r2c1, item_i.elem_r2c0,
                item_i.elem_r1c2, item_i.elem_r1c1, item_i.elem_r1c0,
                item_i.elem_r0c2, item_i.elem_r0c1, item_i.elem_r0c0};
    unique case (item_i.mode) inside
      MODE_1X1: begin
        item_d.size = SIZE_1X1;
        item_d.used = USED_1X1;
      end
      MODE_2X2: begin
        item_d.size = SIZE_2X2;
        item_d.used = USED_2X2;
      end
      MODE_3X3, MODE_3X3_ALT: begin
        item_d.size = SIZE_3X3;
        item_d.used = USED_3X3;
      end
      default: begin
        item_d.size = SIZE_3X3;
        item_d.used = USED_3X3;
      end
    endcase
  end

  // holding register valid flag
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

/* rtl/sml_queue.sv */
// ----------------------------------------------------------------------------
// sml_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module sml_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sml_pkg::cls_item_t item_i,
  input  logic               pop_i,
  output sml_pkg::cls_item_t item_o,
  output sml_pkg::q_stat_t   stat_o
);
  import sml_pkg::*;

  cls_item_t          mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]   count_q;
  logic               do_push, do_pop;

  assign stat_o.full  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/sml_back.sv */
// ----------------------------------------------------------------------------
// sml_back
// Execution unit: one shared multiplier forms the minors and the
// determinant, one restoring divider forms each inverse entry, and an
// output register holds the finished result beat.
// ----------------------------------------------------------------------------
module sml_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sml_pkg::cls_item_t item_i,
  input  sml_pkg::q_stat_t   q_stat_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output sml_pkg::out_item_t result_o
);
  import sml_pkg::*;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  // sign and magnitude into saturated signed 32 bits
  function automatic sat_t sat32(input logic neg, input logic [DET_W-1:0] mag);
    sat_t r;
    r.ovf = neg ? (mag > DET_W'(64'h8000_0000)) : (mag > DET_W'(64'h7FFF_FFFF));
    if (r.ovf) begin
      r.val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r.val = neg ? (32'd0 - mag[31:0]) : mag[31:0];
    end
    return r;
  endfunction

  bstate_e state_q, state_d;

  size_e                         size_q;
  logic [N_ELEM-1:0]             used_q;
  logic [N_ELEM-1:0][ELEM_W-1:0] m_q;
  logic [4:0]                    step_q, step_d;
  logic signed [65:0]            prod_q, prod_d, tmp_q, tmp_d;
  logic [4:0]                    pstep_q, pstep_d;
  logic                          pvld_q, pvld_d;
  logic signed [ADJ_W-1:0]       adj_q [N_ELEM];
  logic signed [ADJ_W-1:0]       adj_d [N_ELEM];
  logic signed [DET_W-1:0]       det_q, det_d;
  logic [REM_W-1:0]              rem_q, rem_d, dsh_q, dsh_d;
  logic [QUO_W-1:0]              quo_q, quo_d;
  logic [5:0]                    bit_q, bit_d;
  logic [3:0]                    elem_q, elem_d;
  logic                          neg_q, neg_d;
  logic [31:0]                   inv_q [N_ELEM];
  logic [31:0]                   inv_d [N_ELEM];
  logic                          ovf_q, ovf_d;
  out_item_t                     out_q, out_d;
  logic                          out_vld_q, out_vld_d;

  logic [DET_W-1:0]              det_mag;
  logic                          det_neg, sing, slot_free, skip;

  assign det_neg   = det_q[DET_W-1];
  assign det_mag   = det_neg ? (DET_W'(0) - det_q) : det_q;
  assign sing      = (det_q == '0);
  assign slot_free = !out_vld_q || pop;
  assign skip      = !used_q[elem_q] || sing;
  assign empty     = !out_vld_q;
  assign result_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE:   if (!q_stat_i.empty) state_d = BS_MUL;
      BS_MUL:    if (step_q == 5'(MUL_LAST)) state_d = BS_DET;
      BS_DET:    state_d = BS_DLOAD;
      BS_DLOAD: begin
        if (!skip) begin
          state_d = BS_DSTEP;
        end else if (elem_q == 4'(N_ELEM-1)) begin
          state_d = BS_OUT;
        end
      end
      BS_DSTEP:  if (bit_q == '0) state_d = BS_DSTORE;
      BS_DSTORE: state_d = (elem_q == 4'(N_ELEM-1)) ? BS_OUT : BS_DLOAD;
      BS_OUT:    if (slot_free) state_d = BS_IDLE;
      default:   state_d = BS_IDLE;
    endcase
  end

  // multiplier operand selection and product
  always_comb begin
    logic [3:0]              j, ia, ib;
    logic [4:0]              dstep;
    logic [1:0]              t;
    logic signed [ADJ_W-1:0] adjv;
    logic signed [32:0]      op_a, op_b;
    j     = step_q[4:1];
    dstep = step_q - 5'(MINOR_STEPS);
    t     = dstep[2:1];
    adjv  = adj_q[DET_ADJ[t]];
    ia    = '0;
    ib    = '0;
    if (step_q < 5'(MINOR_STEPS)) begin
      ia   = step_q[0] ? MINOR_Q[j] : MINOR_P[j];
      ib   = step_q[0] ? MINOR_R[j] : MINOR_S[j];
      op_a = {m_q[ia][31], m_q[ia]};
      op_b = {m_q[ib][31], m_q[ib]};
    end else begin
      // low half unsigned, high half signed
      op_a = step_q[0] ? adjv[64:32] : {1'b0, adjv[31:0]};
      op_b = {m_q[t][31], m_q[t]};
    end
    prod_d = op_a * op_b;
  end

  // datapath updates
  always_comb begin
    logic signed [ADJ_W-1:0] adjv;
    logic [ADJ_W-1:0]        amag;
    logic signed [DET_W-1:0] term;
    logic [QUO_W:0]          qr;
    logic                    rnd, ge;
    sat_t                    s, ds;

    step_d    = step_q;
    pstep_d   = step_q;
    pvld_d    = 1'b0;
    tmp_d     = tmp_q;
    adj_d     = adj_q;
    det_d     = det_q;
    rem_d     = rem_q;
    dsh_d     = dsh_q;
    quo_d     = quo_q;
    bit_d     = bit_q;
    elem_d    = elem_q;
    neg_d     = neg_q;
    inv_d     = inv_q;
    ovf_d     = ovf_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !pop;
    q_pop_o   = 1'b0;

    adjv = adj_q[elem_q];
    amag = adjv[ADJ_W-1] ? (ADJ_W'(0) - adjv) : adjv;
    term = '0;
    qr   = '0;
    rnd  = 1'b0;
    ge   = 1'b0;
    s    = '0;
    ds   = '0;

    unique case (state_q)
      BS_IDLE: begin
        q_pop_o = !q_stat_i.empty;
        step_d  = '0;
        ovf_d   = 1'b0;
      end

      BS_MUL: begin
        step_d = step_q + 1'b1;
        pvld_d = (step_q != 5'(MUL_LAST));
        // retire the product issued last cycle
        if (pvld_q) begin
          if (pstep_q < 5'(MINOR_STEPS)) begin
            if (!pstep_q[0]) begin
              tmp_d = prod_q;
            end else begin
              adj_d[pstep_q[4:1]] = tmp_q[ADJ_W-1:0] - prod_q[ADJ_W-1:0];
            end
          end else begin
            term = DET_W'(prod_q);
            if (pstep_q[0]) begin
              term = term <<< 32;
            end
            det_d = (pstep_q == 5'(MINOR_STEPS)) ? term : det_q + term;
          end
        end
      end

      BS_DET: begin
        elem_d = '0;
        unique case (size_q)
          SIZE_1X1: begin
            det_d    = DET_W'($signed(m_q[0])) <<< (2*FRAC_BITS);
            adj_d[0] = ADJ_W'(1) << (2*FRAC_BITS);
          end
          SIZE_2X2: begin
            det_d    = DET_W'(adj_q[8]) <<< FRAC_BITS;
            adj_d[0] = ADJ_W'($signed(m_q[4])) <<< FRAC_BITS;
            adj_d[1] = (ADJ_W'(0) - ADJ_W'($signed(m_q[1]))) <<< FRAC_BITS;
            adj_d[3] = (ADJ_W'(0) - ADJ_W'($signed(m_q[3]))) <<< FRAC_BITS;
            adj_d[4] = ADJ_W'($signed(m_q[0])) <<< FRAC_BITS;
          end
          default: begin
          end
        endcase
      end

      BS_DLOAD: begin
        rem_d = REM_W'(amag[63:0]) << (2*FRAC_BITS);
        dsh_d = REM_W'(det_mag) << (QUO_W-1);
        quo_d = '0;
        bit_d = 6'(QUO_W-1);
        neg_d = adjv[ADJ_W-1] ^ det_neg;
        if (skip) begin
          inv_d[elem_q] = '0;
          elem_d        = elem_q + 1'b1;
        end
      end

      // one quotient bit a cycle
      BS_DSTEP: begin
        ge    = (rem_q >= dsh_q);
        rem_d = ge ? (rem_q - dsh_q) : rem_q;
        dsh_d = dsh_q >> 1;
        quo_d = {quo_q[QUO_W-2:0], ge};
        bit_d = bit_q - 1'b1;
      end

      BS_DSTORE: begin
        rnd           = ((rem_q << 1) >= REM_W'(det_mag));
        qr            = (QUO_W+1)'(quo_q) + (QUO_W+1)'(rnd);
        s             = sat32(neg_q, DET_W'(qr));
        inv_d[elem_q] = s.val;
        ovf_d         = ovf_q | s.ovf;
        elem_d        = elem_q + 1'b1;
      end

      BS_OUT: begin
        ds = sat32(det_neg, (det_mag >> (2*FRAC_BITS)) + DET_W'(det_mag[2*FRAC_BITS-1]));
        if (slot_free) begin
          out_vld_d      = 1'b1;
          out_d.det_value = ds.val;
          out_d.inv_r0c0 = inv_q[0];
          out_d.inv_r0c1 = inv_q[1];
          out_d.inv_r0c2 = inv_q[2];
          out_d.inv_r1c0 = inv_q[3];
          out_d.inv_r1c1 = inv_q[4];
          out_d.inv_r1c2 = inv_q[5];
          out_d.inv_r2c0 = inv_q[6];
          out_d.inv_r2c1 = inv_q[7];
          out_d.inv_r2c2 = inv_q[8];
          out_d.singular = sing;
          out_d.overflow = ovf_q | ds.ovf;
        end
      end

      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_IDLE;
      out_vld_q <= 1'b0;
      pvld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      pvld_q    <= pvld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      size_q <= item_i.size;
      used_q <= item_i.used;
      m_q    <= item_i.m;
    end
    step_q  <= step_d;
    prod_q  <= prod_d;
    pstep_q <= pstep_d;
    tmp_q   <= tmp_d;
    adj_q   <= adj_d;
    det_q   <= det_d;
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    bit_q   <= bit_d;
    elem_q  <= elem_d;
    neg_q   <= neg_d;
    inv_q   <= inv_d;
    ovf_q   <= ovf_d;
    out_q   <= out_d;
  end

endmodule

/* rtl/small_matrix_det_inverse.sv */
// ----------------------------------------------------------------------------
// small_matrix_det_inverse
// Determinant and inverse of a 1x1, 2x2 or 3x3 signed fixed-point matrix.
//
//   channel   direction  handshake          beat
//   input     in         push / full        item_i   (mode + nine elements)
//   result    out        empty / pop        result_o (det, nine inverse, flags)
//
// A beat goes through a queue pop, 25 multiplier steps, determinant select and
// output, plus a divider pass for each inverse entry the size uses (one
// quotient bit a cycle in the divider); entries it skips, and every entry of
// a singular matrix, are set to zero without a divider pass.
// The front and a two-entry queue keep taking beats while the back works,
// and the back starts the next beat while a result waits to be popped.
// Reset leaves every stage empty; no clearing pass.
// ----------------------------------------------------------------------------
module small_matrix_det_inverse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  sml_pkg::in_item_t  item_i,
  output logic               empty,
  input  logic               pop,
  output sml_pkg::out_item_t result_o
);
  import sml_pkg::*;

  logic      q_push, q_pop;
  cls_item_t q_in, q_out;
  q_stat_t   q_stat;

  sml_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .q_push_o (q_push),
    .q_item_o (q_in),
    .q_stat_i (q_stat)
  );

  sml_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .pop_i  (q_pop),
    .item_o (q_out),
    .stat_o (q_stat)
  );

  sml_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (q_out),
    .q_stat_i (q_stat),
    .q_pop_o  (q_pop),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

endmodule

/* bench/det_inverse_checker.sv */
// ----------------------------------------------------------------------------
// det_inverse_checker
// Watches both channels of the matrix block, predicts the determinant and
// inverse of every accepted matrix and compares them with the results popped.
// ----------------------------------------------------------------------------
module det_inverse_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  sml_pkg::in_item_t  item_i,
  input  logic               empty,
  input  logic               pop,
  input  sml_pkg::out_item_t result_o,
  output int                 errors_o,
  output int                 pending_o
);
  import sml_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [191:0] wide_t;
  typedef logic [191:0] mag_t;

  out_item_t expected_q[$];

  assign pending_o = expected_q.size();

  // magnitude divided by a given magnitude, rounded half up
  function automatic mag_t div_round(mag_t num, mag_t den);
    mag_t quo;
    mag_t rem;
    quo = num / den;
    rem = num % den;
    if ((rem << 1) >= den) quo = quo + 1;
    return quo;
  endfunction

  function automatic logic [31:0] clamp(logic neg, mag_t mag, ref logic ovf);
    if (!neg) begin
      if (mag > 192'h7FFFFFFF) begin
        ovf = 1'b1;
        return 32'h7FFFFFFF;
      end
      return mag[31:0];
    end
    if (mag > 192'h80000000) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return 32'(-mag[31:0]);
  endfunction

  function automatic wide_t minor(longint p, longint s, longint q, longint r);
    wide_t a;
    wide_t b;
    a = wide_t'(p * s);
    b = wide_t'(q * r);
    return a - b;
  endfunction

  function automatic out_item_t invert_matrix(in_item_t it);
    longint     m[9];
    wide_t      adj[9];
    wide_t      det;
    logic [8:0] used;
    logic       ovf;
    logic [31:0] res[9];
    mag_t       q;
    out_item_t  o;
    m[0] = it.elem_r0c0; m[1] = it.elem_r0c1; m[2] = it.elem_r0c2;
    m[3] = it.elem_r1c0; m[4] = it.elem_r1c1; m[5] = it.elem_r1c2;
    m[6] = it.elem_r2c0; m[7] = it.elem_r2c1; m[8] = it.elem_r2c2;
    for (int i = 0; i < 9; i++) adj[i] = '0;
    ovf = 1'b0;
    // adjugate at 32 fraction bits, determinant at 48
    if (it.mode == MODE_1X1) begin
      det = wide_t'(m[0]) <<< 32;
      adj[0] = wide_t'(1) <<< 32;
      used = USED_1X1;
    end else if (it.mode == MODE_2X2) begin
      det = minor(m[0], m[4], m[1], m[3]) <<< FRAC_BITS;
      adj[0] = wide_t'(m[4]) <<< FRAC_BITS;
      adj[1] = wide_t'(-m[1]) <<< FRAC_BITS;
      adj[3] = wide_t'(-m[3]) <<< FRAC_BITS;
      adj[4] = wide_t'(m[0]) <<< FRAC_BITS;
      used = USED_2X2;
    end else begin
      adj[0] = minor(m[4], m[8], m[5], m[7]);
      adj[1] = minor(m[2], m[7], m[1], m[8]);
      adj[2] = minor(m[1], m[5], m[2], m[4]);
      adj[3] = minor(m[6], m[5], m[3], m[8]);
      adj[4] = minor(m[0], m[8], m[2], m[6]);
      adj[5] = minor(m[3], m[2], m[0], m[5]);
      adj[6] = minor(m[3], m[7], m[4], m[6]);
      adj[7] = minor(m[1], m[6], m[0], m[7]);
      adj[8] = minor(m[0], m[4], m[1], m[3]);
      det = adj[0] * wide_t'(m[0]) + adj[3] * wide_t'(m[1]) + adj[6] * wide_t'(m[2]);
      used = USED_3X3;
    end
    o = '0;
    o.singular = (det == 0);
    q = div_round(mag_t'(det < 0 ? -det : det), mag_t'(1) << 32);
    o.det_value = clamp(det < 0, q, ovf);
    for (int i = 0; i < 9; i++) begin
      res[i] = '0;
      if (used[i] && !o.singular) begin
        q = div_round(mag_t'(adj[i] < 0 ? -adj[i] : adj[i]) << 32,
                      mag_t'(det < 0 ? -det : det));
        res[i] = clamp((adj[i] < 0) != (det < 0), q, ovf);
      end
    end
    o.inv_r0c0 = res[0]; o.inv_r0c1 = res[1]; o.inv_r0c2 = res[2];
    o.inv_r1c0 = res[3]; o.inv_r1c1 = res[4]; o.inv_r1c2 = res[5];
    o.inv_r2c0 = res[6]; o.inv_r2c1 = res[7]; o.inv_r2c2 = res[8];
    o.overflow = ovf;
    return o;
  endfunction

  // predict on input beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (push && !full) expected_q.push_back(invert_matrix(item_i));
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result beat: %h", result_o);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== result_o) begin
            if (errors_o < 10)
              $display("mismatch: expected %h got %h", want, result_o);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random matrices of every size into the determinant and
// inverse block with random gaps on both sides; the checker does the scoring.
// ----------------------------------------------------------------------------
module testbench;
  import sml_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1950;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  item_i;
  logic      empty;
  logic      pop;
  out_item_t result_o;
  int        errors;
  int        pending;
  logic      calm;

  small_matrix_det_inverse dut (.*);

  det_inverse_checker checker_i (
    .clk_i, .rst_ni, .push, .full, .item_i, .empty, .pop, .result_o,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side stalls at random outside the calm stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(99) >= 38);
    end
  end

  // one input beat, with a random gap ahead of it
  task automatic send_matrix(in_item_t it);
    while (!calm && $urandom_range(99) < 38) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      2:       return 32'($signed($urandom_range(64)) - 32);
      default: return ($urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000) ^ $urandom_range(3);
    endcase
  endfunction

  function automatic in_item_t make_matrix(logic [1:0] mode, logic [31:0] a, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d, logic [31:0] e,
                                           logic [31:0] f, logic [31:0] g, logic [31:0] h,
                                           logic [31:0] k);
    in_item_t it;
    it = '{mode, a, b, c, d, e, f, g, h, k};
    return it;
  endfunction

  initial begin
    in_item_t  it;
    logic [31:0] one;
    one    = 32'h00010000;
    rst_ni = 1'b0;
    push   = 1'b0;
    calm   = 1'b0;
    item_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, singular, tiny determinant, overflow, unused size code
    send_matrix(make_matrix(MODE_1X1, one, 1, 2, 3, 4, 5, 6, 7, 8));
    send_matrix(make_matrix(MODE_1X1, 0, $urandom(), 0, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(MODE_1X1, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(MODE_1X1, 32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(MODE_1X1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(MODE_1X1, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(MODE_2X2, one, 0, 9, 0, one, 9, 9, 9, 9));
    send_matrix(make_matrix(MODE_2X2, one, 2*one, 0, 2*one, 4*one, 0, 0, 0, 0));
    send_matrix(make_matrix(MODE_2X2, 32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF,
                            32'h7FFFFFFF, 0, 0, 0, 0));
    send_matrix(make_matrix(MODE_2X2, 32'h80000000, 32'h80000000, 0, 32'h80000000,
                            32'h7FFFFFFF, 0, 0, 0, 0));
    send_matrix(make_matrix(MODE_2X2, 1, 0, 0, 0, 1, 0, 0, 0, 0));
    send_matrix(make_matrix(MODE_3X3, one, 0, 0, 0, one, 0, 0, 0, one));
    send_matrix(make_matrix(MODE_3X3, one, 2*one, 3*one, 4*one, 5*one, 6*one,
                            7*one, 8*one, 9*one));
    send_matrix(make_matrix(MODE_3X3, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(make_matrix(MODE_3X3, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                            32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                            32'h80000000, 32'h80000000, 32'h80000000));
    send_matrix(make_matrix(MODE_3X3, 32'h80000000, 0, 0, 0, 32'h80000000, 0,
                            0, 0, 32'h80000000));
    send_matrix(make_matrix(MODE_3X3_ALT, 2*one, one, 0, one, 2*one, one, 0, one, 2*one));
    send_matrix(make_matrix(MODE_3X3_ALT, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // random: mostly well-conditioned sizes, some copied rows for singular cases
    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 900 && n < 1100);
      it = make_matrix(2'($urandom_range(3)), rand_elem(), rand_elem(), rand_elem(),
                       rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                       rand_elem());
      if ($urandom_range(9) == 0) begin
        it.elem_r1c0 = it.elem_r0c0;
        it.elem_r1c1 = it.elem_r0c1;
        it.elem_r1c2 = it.elem_r0c2;
      end
      send_matrix(it);
    end
    push <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
